@@ rtl/krs_pkg.sv @@
// ----------------------------------------------------------------------------
// krs_pkg
// Shared types and constants for the keyed running statistics block.
// ----------------------------------------------------------------------------
package krs_pkg;

   localparam int DEVICES   = 64;
   localparam int KEY_CHARS = 19;
   localparam int KEY_W     = 152;
   localparam int IDX_W     = $clog2(DEVICES);
   localparam int USED_W    = $clog2(DEVICES + 1);
   localparam int CNT_W     = 24;
   localparam int VAL_W     = 32;
   localparam int SUM_W     = 56;
   localparam int CNT_ITERS = CNT_W;

   localparam logic [1:0] SEV_WARNING  = 2'd1;
   localparam logic [1:0] SEV_CRITICAL = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [VAL_W-1:0] smallest;
      logic signed [VAL_W-1:0] largest;
      logic signed [SUM_W-1:0] total;
      logic [CNT_W-1:0]        warn;
      logic [CNT_W-1:0]        crit;
   } stats_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             used;
      stats_type        stats;
   } entry_type;

   // request travelling along the chain
   typedef struct packed {
      logic                    active;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] sample;
      logic [1:0]              severity;
      logic                    found;
      logic [IDX_W-1:0]        index;
   } token_type;

   typedef struct packed {
      logic [IDX_W-1:0]        entry_index;
      logic                    created;
      logic                    table_full;
      logic [CNT_W-1:0]        reading_count;
      logic signed [VAL_W-1:0] smallest;
      logic signed [VAL_W-1:0] largest;
      logic signed [SUM_W-1:0] total;
      logic signed [VAL_W-1:0] mean;
      logic [CNT_W-1:0]        warning_count;
      logic [CNT_W-1:0]        critical_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0]             key_low;
      logic [63:0]             key_middle;
      logic [23:0]             key_high;
      logic signed [VAL_W-1:0] sample;
      logic [1:0]              severity;
   } req_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] k;
      logic ended;
      k = '0;
      ended = 1'b0;
      for (int i = 0; i < KEY_W/8; i++) begin
         if (i >= KEY_CHARS || raw[8*i +: 8] == 8'd0) ended = 1'b1;
         k[8*i +: 8] = ended ? 8'd0 : raw[8*i +: 8];
      end
      return k;
   endfunction

endpackage

@@ rtl/krs_stream_if.sv @@
// ----------------------------------------------------------------------------
// krs_stream_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface krs_req_if;
   logic                valid;
   logic                ready;
   krs_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface krs_rsp_if;
   logic                valid;
   logic                ready;
   krs_pkg::rsp_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/keyed_running_statistics.sv @@
// ----------------------------------------------------------------------------
// keyed_running_statistics
// Per-device count, min, max, sum and severity counters in a chain of slots.
// Each reading passes through the DEVICES slots of the chain, then the divider,
// then a registered output; a new reading is taken only once the last result
// has been transferred.
// Reset: synchronous; clears all slot used bits, table reads as empty.
// ----------------------------------------------------------------------------
module keyed_running_statistics (
   input  logic          clock,
   input  logic          reset,
   krs_req_if.sink       req,
   krs_rsp_if.source     rsp
);
   localparam int N = krs_pkg::DEVICES;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_CHAIN = 4'b0010, ST_DIV = 4'b0100, ST_OUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   krs_pkg::token_type tok [0:N];
   krs_pkg::token_type tok_head;
   krs_pkg::stats_type st [0:N-1];
   logic [N-1:0] hit;
   logic [N-1:0] claim;
   krs_pkg::stats_type cap_ff;
   krs_pkg::stats_type cap_sel;
   logic full_ff;
   logic [krs_pkg::IDX_W-1:0] idx_ff;
   krs_pkg::rsp_type rsp_ff, rsp_in;
   logic div_start, div_done;
   logic signed [krs_pkg::VAL_W-1:0] div_q;
   logic [krs_pkg::IDX_W-1:0] hit_idx;
   logic [N-1:0] hit_ff;
   logic claim_seen_ff;

   always_comb begin
      tok_head = '0;
      tok_head.active   = req.valid && req.ready;
      tok_head.key      = krs_pkg::norm_key({req.data.key_high, req.data.key_middle,
                                             req.data.key_low});
      tok_head.sample   = req.data.sample;
      tok_head.severity = req.data.severity;
   end

   assign tok[0] = tok_head;

   for (genvar g = 0; g < N; g++) begin : g_cell
      krs_cell u_cell (
         .clock(clock), .reset(reset), .slot(krs_pkg::IDX_W'(g)),
         .tok_in(tok[g]), .tok_out(tok[g+1]), .stats(st[g]), .hit(hit[g]),
         .claim(claim[g]));
   end

   assign hit_idx = tok[N].index;

   // the hitting slot's stats are valid the cycle after it hit
   always_ff @(posedge clock) begin
      if (reset) hit_ff <= '0;
      else       hit_ff <= hit;
      for (int i = 0; i < N; i++)
         if (hit_ff[i]) cap_ff <= st[i];
   end

   assign div_start = (state_ff == ST_CHAIN) && tok[N].active;

   always_ff @(posedge clock) begin
      if (div_start) begin
         full_ff <= !tok[N].found;
         idx_ff  <= hit_idx;
      end
   end

   always_comb begin
      cap_sel = cap_ff;
      for (int i = 0; i < N; i++)
         if (hit_ff[i]) cap_sel = st[i];
   end

   krs_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(cap_sel.total),
      .divisor(cap_sel.count | {{(krs_pkg::CNT_W-1){1'b0}}, !tok[N].found}),
      .done(div_done), .quotient(div_q));

   // slot 0 claims in the transfer cycle, so a claim wins over the idle clear
   always_ff @(posedge clock) begin
      if (reset) claim_seen_ff <= 1'b0;
      else if (|claim) claim_seen_ff <= 1'b1;
      else if (state_ff == ST_IDLE) claim_seen_ff <= 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req.valid) state_in = ST_CHAIN;
         ST_CHAIN: if (tok[N].active) state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_OUT;
         ST_OUT:   if (rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (state_ff == ST_DIV && div_done) begin
         rsp_in = '0;
         if (full_ff) rsp_in.table_full = 1'b1;
         else begin
            rsp_in.entry_index    = idx_ff;
            rsp_in.created        = claim_seen_ff;
            rsp_in.reading_count  = cap_ff.count;
            rsp_in.smallest       = cap_ff.smallest;
            rsp_in.largest        = cap_ff.largest;
            rsp_in.total          = cap_ff.total;
            rsp_in.mean           = div_q;
            rsp_in.warning_count  = cap_ff.warn;
            rsp_in.critical_count = cap_ff.crit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      rsp_ff <= rsp_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.data  = rsp_ff;

   a_one_hit: assert property (@(posedge clock) disable iff (reset) $onehot0(hit))
      else $error("more than one slot took the reading");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   a_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("divider done out of state");
endmodule

@@ rtl/krs_cell.sv @@
// ----------------------------------------------------------------------------
// krs_cell
// One table slot: compares the passing key, claims itself when free and
// updates its statistics, then hands the token to the next slot.
// ----------------------------------------------------------------------------
module krs_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [krs_pkg::IDX_W-1:0]  slot,
   input  krs_pkg::token_type         tok_in,
   output krs_pkg::token_type         tok_out,
   output krs_pkg::stats_type         stats,
   output logic                       hit,
   output logic                       claim
);
   krs_pkg::token_type tok_ff, tok_in_v;
   logic [krs_pkg::KEY_W-1:0] key_ff, key_in;
   logic used_ff, used_in;
   krs_pkg::stats_type st_ff, st_in;
   logic take;
   logic signed [krs_pkg::SUM_W:0] s_wide;

   assign take = tok_in.active && !tok_in.found &&
                 (!used_ff || key_ff == tok_in.key);

   always_comb begin
      key_in  = key_ff;
      used_in = used_ff;
      st_in   = st_ff;
      tok_in_v = tok_in;
      s_wide  = '0;
      if (take) begin
         tok_in_v.found = 1'b1;
         tok_in_v.index = slot;
         if (!used_ff) begin
            used_in = 1'b1;
            key_in  = tok_in.key;
            st_in.count    = krs_pkg::CNT_W'(1);
            st_in.smallest = tok_in.sample;
            st_in.largest  = tok_in.sample;
            st_in.total    = krs_pkg::SUM_W'(tok_in.sample);
            st_in.warn     = '0;
            st_in.crit     = '0;
         end else begin
            if (tok_in.sample < st_ff.smallest) st_in.smallest = tok_in.sample;
            if (tok_in.sample > st_ff.largest)  st_in.largest  = tok_in.sample;
            st_in.count = krs_pkg::sat_inc(st_ff.count);
            s_wide = (krs_pkg::SUM_W+1)'(st_ff.total) + (krs_pkg::SUM_W+1)'(tok_in.sample);
            if (s_wide > (krs_pkg::SUM_W+1)'(krs_pkg::SUM_MAX))
               st_in.total = krs_pkg::SUM_MAX;
            else if (s_wide < (krs_pkg::SUM_W+1)'(krs_pkg::SUM_MIN))
               st_in.total = krs_pkg::SUM_MIN;
            else
               st_in.total = s_wide[krs_pkg::SUM_W-1:0];
         end
         if (tok_in.severity == krs_pkg::SEV_WARNING)
            st_in.warn = krs_pkg::sat_inc(used_ff ? st_ff.warn : '0);
         if (tok_in.severity == krs_pkg::SEV_CRITICAL)
            st_in.crit = krs_pkg::sat_inc(used_ff ? st_ff.crit : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         used_ff <= used_in;
         tok_ff.active <= tok_in_v.active;
      end
      key_ff <= key_in;
      st_ff  <= st_in;
      tok_ff.key <= tok_in_v.key;
      tok_ff.sample <= tok_in_v.sample;
      tok_ff.severity <= tok_in_v.severity;
      tok_ff.found <= tok_in_v.found;
      tok_ff.index <= tok_in_v.index;
   end

   assign tok_out = tok_ff;
   assign stats   = st_ff;
   assign hit     = take;
   assign claim   = take && !used_ff;
endmodule

@@ rtl/krs_divider.sv @@
// ----------------------------------------------------------------------------
// krs_divider
// Restoring divider, one quotient bit per cycle, signed total over count,
// truncated toward zero and clamped to 32 bits.
// ----------------------------------------------------------------------------
module krs_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [krs_pkg::SUM_W-1:0]   dividend,
   input  logic [krs_pkg::CNT_W-1:0]          divisor,
   output logic                               done,
   output logic signed [krs_pkg::VAL_W-1:0]   quotient
);
   localparam int SW = krs_pkg::SUM_W;
   logic [SW-1:0] q_ff, q_in;
   logic [krs_pkg::CNT_W:0] r_ff, r_in;
   logic [krs_pkg::CNT_W-1:0] d_ff;
   logic neg_ff, busy_ff, done_ff;
   logic [$clog2(SW+1)-1:0] n_ff;
   logic [krs_pkg::CNT_W:0] trial;
   logic [SW-1:0] mag, qs;

   assign mag = dividend[SW-1] ? (~dividend + 1'b1) : dividend;

   always_comb begin
      trial = {r_ff[krs_pkg::CNT_W-1:0], q_ff[SW-1]};
      q_in  = {q_ff[SW-2:0], 1'b0};
      r_in  = trial;
      if (trial >= {1'b0, d_ff}) begin
         r_in = trial - {1'b0, d_ff};
         q_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            n_ff    <= '0;
         end else if (busy_ff) begin
            n_ff <= n_ff + 1'b1;
            if (n_ff == ($clog2(SW+1))'(SW-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         q_ff <= mag; r_ff <= '0; d_ff <= divisor; neg_ff <= dividend[SW-1];
      end else if (busy_ff) begin
         q_ff <= q_in; r_ff <= r_in;
      end
   end

   // quotient magnitude clamps to 2^31-1 or -2^31
   assign qs = neg_ff ? (~q_ff + 1'b1) : q_ff;
   always_comb begin
      if (!neg_ff && q_ff > SW'(32'h7FFF_FFFF))
         quotient = 32'sh7FFF_FFFF;
      else if (neg_ff && q_ff > SW'(33'h8000_0000))
         quotient = 32'sh8000_0000;
      else
         quotient = qs[krs_pkg::VAL_W-1:0];
   end
   assign done = done_ff;
endmodule
